### rtl/dtcp_pkg.sv
// ----------------------------------------------------------------------------
// dtcp_pkg
// Shared types and constants of the DTC response parser.
// ----------------------------------------------------------------------------
package dtcp_pkg;

  localparam int unsigned MaxFrameBytes = 4096;
  localparam int unsigned PosW          = $clog2(MaxFrameBytes + 1);

  localparam logic [7:0] NegResponse = 8'h7F;
  localparam logic [7:0] ReadDtcSid  = 8'h19;
  localparam logic [7:0] PosOffset   = 8'h40;
  localparam logic [7:0] ByteMask    = 8'hFF;
  localparam logic [7:0] PosResponse = (ReadDtcSid + PosOffset) & ByteMask;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KIND_DTC  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] dtc_code;
    logic [7:0]  dtc_status;
    logic [15:0] ecu_id;
    logic        last;
  } result_t;

endpackage

### rtl/dtcp_parse.sv
// ----------------------------------------------------------------------------
// dtcp_parse
// Per-byte frame parser: prefix detection, service decoding and record
// extraction. Produces up to two results for each accepted byte.
// ----------------------------------------------------------------------------
module dtcp_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  frame_end_i,
  input  logic                  batch_end_i,
  input  logic [7:0]            status_mask_i,
  output dtcp_pkg::result_t     res0_o,
  output dtcp_pkg::result_t     res1_o,
  output logic [1:0]            res_cnt_o
);

  logic [dtcp_pkg::PosW-1:0] pos_q, pos_d, p;
  logic                      fpz_q, fpz_d, fpz_new;
  logic                      hp_q, hp_d, hp_new;
  logic [15:0]               src_q, src_d;
  logic [7:0]                svc_q, svc_d;
  logic [23:0]               code_q, code_d;
  logic                      failed_q, failed_d;
  logic                      active, in_prefix, rec_emit, fail_emit, done_emit;
  logic [15:0]               ecu;
  dtcp_pkg::result_t         rec_res, done_res;

  assign active  = !failed_q && (pos_q < dtcp_pkg::PosW'(dtcp_pkg::MaxFrameBytes));
  assign fpz_new = (pos_q == '0) ? (data_byte_i == 8'h00) : fpz_q;
  assign hp_new  = (pos_q == dtcp_pkg::PosW'(1)) ? (fpz_q && data_byte_i == 8'h00) : hp_q;
  assign in_prefix = hp_new && (pos_q < dtcp_pkg::PosW'(4));
  assign p   = hp_new ? (pos_q - dtcp_pkg::PosW'(4)) : pos_q;
  assign ecu = hp_new ? src_q : 16'h0000;

  always_comb begin
    pos_d     = pos_q;
    fpz_d     = fpz_q;
    hp_d      = hp_q;
    src_d     = src_q;
    svc_d     = svc_q;
    code_d    = code_q;
    failed_d  = failed_q;
    rec_emit  = 1'b0;
    fail_emit = 1'b0;
    if (active) begin
      fpz_d = fpz_new;
      hp_d  = hp_new;
      if (in_prefix) begin
        if (pos_q == dtcp_pkg::PosW'(2)) begin
          src_d = {data_byte_i, 8'h00};
        end else if (pos_q == dtcp_pkg::PosW'(3)) begin
          src_d = {src_q[15:8], data_byte_i};
        end
      end else if (p == '0) begin
        svc_d = data_byte_i;
      end else if (p >= dtcp_pkg::PosW'(3)) begin
        if (svc_q == dtcp_pkg::NegResponse) begin
          if (p == dtcp_pkg::PosW'(3)) begin
            fail_emit = 1'b1;
            failed_d  = 1'b1;
          end
        end else if (svc_q == dtcp_pkg::PosResponse) begin
          if (p[1:0] != 2'd2) begin
            code_d = {code_q[15:0], data_byte_i};
          end else if ((data_byte_i & status_mask_i) != 8'h00) begin
            rec_emit = 1'b1;
          end
        end
      end
    end
    if (pos_q < dtcp_pkg::PosW'(dtcp_pkg::MaxFrameBytes)) begin
      pos_d = pos_q + dtcp_pkg::PosW'(1);
    end
    done_emit = batch_end_i && !failed_d;
    if (batch_end_i || frame_end_i) begin
      pos_d  = '0;
      fpz_d  = 1'b1;
      hp_d   = 1'b0;
      src_d  = 16'h0000;
      svc_d  = 8'h00;
      code_d = 24'h000000;
    end
    if (batch_end_i) begin
      failed_d = 1'b0;
    end
  end

  always_comb begin
    rec_res.kind       = rec_emit ? dtcp_pkg::KIND_DTC : dtcp_pkg::KIND_FAIL;
    rec_res.dtc_code   = rec_emit ? code_q : 24'h000000;
    rec_res.dtc_status = rec_emit ? data_byte_i : 8'h00;
    rec_res.ecu_id     = ecu;
    rec_res.last       = !done_emit;
    done_res.kind       = dtcp_pkg::KIND_DONE;
    done_res.dtc_code   = 24'h000000;
    done_res.dtc_status = 8'h00;
    done_res.ecu_id     = 16'h0000;
    done_res.last       = 1'b1;
    if (rec_emit || fail_emit) begin
      res0_o    = rec_res;
      res1_o    = done_res;
      res_cnt_o = done_emit ? 2'd2 : 2'd1;
    end else begin
      res0_o    = done_res;
      res1_o    = done_res;
      res_cnt_o = done_emit ? 2'd1 : 2'd0;
    end
    if (!fire_i) begin
      res_cnt_o = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      fpz_q    <= 1'b1;
      hp_q     <= 1'b0;
      src_q    <= 16'h0000;
      svc_q    <= 8'h00;
      code_q   <= 24'h000000;
      failed_q <= 1'b0;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      fpz_q    <= fpz_d;
      hp_q     <= hp_d;
      src_q    <= src_d;
      svc_q    <= svc_d;
      code_q   <= code_d;
      failed_q <= failed_d;
    end
  end

endmodule

### rtl/dtcp_queue.sv
// ----------------------------------------------------------------------------
// dtcp_queue
// Small result queue taking up to two results per cycle and giving one per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module dtcp_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dtcp_pkg::result_t              push0_i,
  input  dtcp_pkg::result_t              push1_i,
  input  logic [1:0]                     push_cnt_i,
  output logic                           room_o,
  output logic                           valid_o,
  input  logic                           ready_i,
  output dtcp_pkg::result_t              data_o
);

  dtcp_pkg::result_t                mem_q [dtcp_pkg::QueueDepth];
  logic [dtcp_pkg::QueuePtrW-1:0]   wr_q, rd_q;
  logic [dtcp_pkg::QueueCntW-1:0]   cnt_q, cnt_d;
  logic                             pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign room_o  = (cnt_q <= dtcp_pkg::QueueCntW'(dtcp_pkg::QueueDepth - 2));
  assign data_o  = mem_q[rd_q];
  assign cnt_d   = cnt_q + dtcp_pkg::QueueCntW'(push_cnt_i)
                   - dtcp_pkg::QueueCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_q + dtcp_pkg::QueuePtrW'(1)] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + dtcp_pkg::QueuePtrW'(push_cnt_i);
      rd_q  <= rd_q + dtcp_pkg::QueuePtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/dtc_response_parser.sv
// ----------------------------------------------------------------------------
// dtc_response_parser
// Streaming parser for diagnostic DTC response frames, one byte per request.
// ----------------------------------------------------------------------------
// The block accepts one byte request in every cycle while the queue has room
// and decodes it in that cycle; each byte yields zero, one or two results,
// which enter a four-entry result queue. Input is ready while the queue has
// room for two results. The queue delivers one result per cycle while the
// output is ready, so the output port limits long runs of two-result bytes.
module dtc_response_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_status_mask_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  input  logic        batch_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [23:0] dtc_code_o,
  output logic [7:0]  dtc_status_o,
  output logic [15:0] ecu_id_o,
  output logic        last_o
);

  logic [7:0]        status_mask_q;
  logic              fire, room;
  logic [1:0]        res_cnt;
  dtcp_pkg::result_t res0, res1, head;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = room;
  assign fire        = in_valid_i && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_mask_q <= dtcp_pkg::ByteMask;
    end else if (cfg_valid_i) begin
      status_mask_q <= cfg_status_mask_i;
    end
  end

  dtcp_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .data_byte_i   (data_byte_i),
    .frame_end_i   (frame_end_i),
    .batch_end_i   (batch_end_i),
    .status_mask_i (status_mask_q),
    .res0_o        (res0),
    .res1_o        (res1),
    .res_cnt_o     (res_cnt)
  );

  dtcp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push0_i    (res0),
    .push1_i    (res1),
    .push_cnt_i (res_cnt),
    .room_o     (room),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (head)
  );

  assign kind_o       = head.kind;
  assign dtc_code_o   = head.dtc_code;
  assign dtc_status_o = head.dtc_status;
  assign ecu_id_o     = head.ecu_id;
  assign last_o       = head.last;

endmodule
